// File: rtl/core/wwgm_pkg.sv
// ----------------------------------------------------------------------------
// wwgm_pkg: shared types and constants of the weighted grid merge
// Widths, register indexes, the job record and the back-end state encoding.
// ----------------------------------------------------------------------------
package wwgm_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DATA_W        = 32;
    localparam int IDX_W         = 10;
    localparam int WIN_SIZE      = 9;
    localparam int SUM_W         = 37;
    localparam int PROD_W        = 41;
    localparam int DIV_W         = 42;
    localparam int DIV_STEP      = 7;
    localparam int DIVISOR_W     = 4;
    localparam int COUNT_W       = 4;
    localparam int K_W           = 4;
    localparam int WEIGHT_W      = 5;
    localparam int ROW_W         = 2;
    localparam int WEIGHT_CAP    = 9;
    localparam int SCALE_DIV     = 10;
    localparam int QUEUE_DEPTH   = 2;
    localparam int ADDR_W        = 4;

    localparam logic [1:0] REG_NULL_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_CENTER_ROW     = 2'd1;
    localparam logic [1:0] REG_COUNT_GAIN     = 2'd2;

    typedef struct packed {
        logic [WIN_SIZE-1:0][DATA_W-1:0] merge;
        logic [WIN_SIZE-1:0][DATA_W-1:0] regional;
        logic [DATA_W-1:0]               here;
        logic [IDX_W-1:0]                column_index;
    } job_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   null_threshold;
        logic [ROW_W-1:0]           center_row;
        logic signed [WEIGHT_W-1:0] count_gain;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     mag;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SUM,
        B_CHK,
        B_DIV1,
        B_MUL,
        B_GO,
        B_DIV2,
        B_OUT
    } back_state_t;

endpackage

// File: rtl/core/wwgm_channels.sv
// ----------------------------------------------------------------------------
// wwgm_channels: valid/ready channels of the weighted grid merge
// One interface for grid columns in, one for merged results out.
// ----------------------------------------------------------------------------
interface wwgm_col_if;
    import wwgm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] merge_top;
    logic signed [DATA_W-1:0] merge_mid;
    logic signed [DATA_W-1:0] merge_bot;
    logic signed [DATA_W-1:0] regional_top;
    logic signed [DATA_W-1:0] regional_mid;
    logic signed [DATA_W-1:0] regional_bot;
    logic signed [DATA_W-1:0] regional_here;
    logic                     first_column;

    modport source (
        output valid, merge_top, merge_mid, merge_bot,
        output regional_top, regional_mid, regional_bot, regional_here, first_column,
        input  ready
    );
    modport sink (
        input  valid, merge_top, merge_mid, merge_bot,
        input  regional_top, regional_mid, regional_bot, regional_here, first_column,
        output ready
    );
endinterface

interface wwgm_res_if;
    import wwgm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] merged_value;
    logic [IDX_W-1:0]         column_index;

    modport source (output valid, merged_value, column_index, input ready);
    modport sink (input valid, merged_value, column_index, output ready);
endinterface

// File: rtl/core/window_weighted_grid_merge.sv
// ----------------------------------------------------------------------------
// window_weighted_grid_merge: streaming 3x3 weighted grid merge
// Column intake, a two-entry window queue and a sequenced evaluator with a
// shared divider, configured over an APB-style register port.
//
//   Channel   Direction  Transaction
//   columns   in         one grid column: three merge and four regional values
//   results   out        merged value and column index of the window centre
//   apb       in/out     register writes and reads
//
// A column that yields no result is taken by the front end and never reaches the queue.
// An empty or passed-through window bypasses the divider, a window with a
// valid centre sample uses it once and any other twice, at 7 bits a cycle.
// Reset clears control state only; the window holds no valid bits.
// The queue lets intake continue while the evaluator or the output stalls.
// ----------------------------------------------------------------------------
module window_weighted_grid_merge #(
    parameter int MAX_WIDTH = wwgm_pkg::DEF_MAX_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    wwgm_col_if.sink                      columns,
    wwgm_res_if.source                    results,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wwgm_pkg::ADDR_W-1:0]   paddr,
    input  logic [wwgm_pkg::DATA_W-1:0]   pwdata,
    output logic [wwgm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import wwgm_pkg::*;

    cfg_t              cfg_reg, cfg_next;
    logic              wr_en;
    logic [1:0]        reg_sel;
    logic              push;
    job_t              push_job;
    logic              pop;
    job_t              head;
    logic              head_valid;
    logic              full;
    div_req_t          div_req;
    logic              div_busy;
    logic [DIV_W-1:0]  div_quotient;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_NULL_THRESHOLD: cfg_next.null_threshold = pwdata;
                REG_CENTER_ROW:     cfg_next.center_row     = pwdata[ROW_W-1:0];
                REG_COUNT_GAIN:     cfg_next.count_gain     = pwdata[WEIGHT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_NULL_THRESHOLD: prdata = cfg_reg.null_threshold;
            REG_CENTER_ROW:     prdata = DATA_W'(cfg_reg.center_row);
            REG_COUNT_GAIN:     prdata = DATA_W'(cfg_reg.count_gain);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.null_threshold <= {1'b0, {(DATA_W-1){1'b1}}};
            cfg_reg.center_row     <= ROW_W'(1);
            cfg_reg.count_gain     <= WEIGHT_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wwgm_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .columns  (columns),
        .full     (full),
        .push     (push),
        .push_job (push_job)
    );

    wwgm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    wwgm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    wwgm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .div_req      (div_req),
        .div_busy     (div_busy),
        .div_quotient (div_quotient),
        .results      (results)
    );

endmodule

// File: rtl/core/wwgm_div.sv
// ----------------------------------------------------------------------------
// wwgm_div: shared small-divisor long divider
// Divides an unsigned magnitude by a 4-bit divisor, several bits per cycle.
// ----------------------------------------------------------------------------
module wwgm_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  wwgm_pkg::div_req_t                 req,
    output logic                               busy,
    output logic [wwgm_pkg::DIV_W-1:0]         quotient
);
    import wwgm_pkg::*;

    localparam int ROUNDS = DIV_W / DIV_STEP;
    localparam int RND_W  = $clog2(ROUNDS + 1);

    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] d_reg, d_next;
    logic [RND_W-1:0]     rounds_reg, rounds_next;
    logic [DIV_W-1:0]     q_step;
    logic [DIVISOR_W-1:0] rem_step;

    always_comb
    begin
        logic [DIVISOR_W:0] trial;
        rem_step = rem_reg;
        q_step   = dvd_reg;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial  = {rem_step, q_step[DIV_W-1]};
            q_step = {q_step[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                rem_step  = DIVISOR_W'(trial - {1'b0, d_reg});
                q_step[0] = 1'b1;
            end
            else
            begin
                rem_step = trial[DIVISOR_W-1:0];
            end
        end
    end

    always_comb
    begin
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        d_next      = d_reg;
        rounds_next = rounds_reg;
        if (req.start)
        begin
            dvd_next    = req.mag;
            rem_next    = '0;
            d_next      = req.divisor;
            rounds_next = RND_W'(ROUNDS);
        end
        else if (rounds_reg != '0)
        begin
            dvd_next    = q_step;
            rem_next    = rem_step;
            rounds_next = rounds_reg - RND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rounds_reg <= '0;
        end
        else
        begin
            rounds_reg <= rounds_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign busy     = (rounds_reg != '0);
    assign quotient = dvd_reg;

endmodule

// File: rtl/core/wwgm_queue.sv
// ----------------------------------------------------------------------------
// wwgm_queue: two-entry job queue between front and back
// Holds complete 3x3 windows so that either side can stall on its own.
// ----------------------------------------------------------------------------
module wwgm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wwgm_pkg::job_t push_job,
    input  logic           pop,
    output wwgm_pkg::job_t head,
    output logic           head_valid,
    output logic           full
);
    import wwgm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (fill_reg != '0);
    assign full       = (fill_reg == CNT_W'(QUEUE_DEPTH));

endmodule

// File: rtl/core/wwgm_front.sv
// ----------------------------------------------------------------------------
// wwgm_front: column intake and window keeping
// Tracks the column position, keeps the two previous columns and issues
// a window job for every interior column.
// ----------------------------------------------------------------------------
module wwgm_front #(
    parameter int MAX_WIDTH = wwgm_pkg::DEF_MAX_WIDTH
) (
    input  logic           clk,
    input  logic           rst_n,
    wwgm_col_if.sink       columns,
    input  logic           full,
    output logic           push,
    output wwgm_pkg::job_t push_job
);
    import wwgm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);

    logic [DATA_W-1:0] win_merge_reg [6];
    logic [DATA_W-1:0] win_regional_reg [6];
    logic [DATA_W-1:0] win_here_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     col;
    logic [CW-1:0]     col_prev;
    logic [CW+IDX_W-1:0] idx_ext;
    logic              take;
    logic              in_range;
    logic [DATA_W-1:0] cur_merge [3];
    logic [DATA_W-1:0] cur_regional [3];

    assign cur_merge[0]    = columns.merge_top;
    assign cur_merge[1]    = columns.merge_mid;
    assign cur_merge[2]    = columns.merge_bot;
    assign cur_regional[0] = columns.regional_top;
    assign cur_regional[1] = columns.regional_mid;
    assign cur_regional[2] = columns.regional_bot;

    assign columns.ready = !full;
    assign take          = columns.valid && !full;
    assign col           = columns.first_column ? '0 : count_reg;
    assign in_range      = (col < CW'(MAX_WIDTH));
    assign push          = take && in_range && (col > CW'(1));
    assign col_prev      = col - CW'(1);
    assign idx_ext       = {{IDX_W{1'b0}}, col_prev};

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            push_job.merge[r]        = win_merge_reg[r];
            push_job.merge[3 + r]    = win_merge_reg[3 + r];
            push_job.merge[6 + r]    = cur_merge[r];
            push_job.regional[r]     = win_regional_reg[r];
            push_job.regional[3 + r] = win_regional_reg[3 + r];
            push_job.regional[6 + r] = cur_regional[r];
        end
        push_job.here         = win_here_reg;
        push_job.column_index = idx_ext[IDX_W-1:0];
    end

    always_comb
    begin
        count_next = count_reg;
        if (take && in_range)
        begin
            count_next = col + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_range)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_merge_reg[r]        <= win_merge_reg[3 + r];
                win_regional_reg[r]     <= win_regional_reg[3 + r];
                win_merge_reg[3 + r]    <= cur_merge[r];
                win_regional_reg[3 + r] <= cur_regional[r];
            end
            win_here_reg <= columns.regional_here;
        end
    end

endmodule

// File: rtl/core/wwgm_back.sv
// ----------------------------------------------------------------------------
// wwgm_back: window evaluation sequencer
// Sums the window one column a cycle, divides by the count (invalid centre)
// and by ten on the shared divider, saturates, holds the result for output.
// ----------------------------------------------------------------------------
module wwgm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wwgm_pkg::cfg_t       cfg,
    input  wwgm_pkg::job_t       head,
    input  logic                 head_valid,
    output logic                 pop,
    output wwgm_pkg::div_req_t   div_req,
    input  logic                 div_busy,
    input  logic [wwgm_pkg::DIV_W-1:0] div_quotient,
    wwgm_res_if.source           results
);
    import wwgm_pkg::*;

    back_state_t               state_reg, state_next;
    logic [1:0]                c_reg, c_next;
    logic signed [SUM_W-1:0]   acc_reg, acc_next;
    logic [COUNT_W-1:0]        cnt_reg, cnt_next;
    logic [K_W-1:0]            k_reg, k_next;
    logic signed [SUM_W-1:0]   avg_reg, avg_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [DATA_W-1:0]         res_reg, res_next;
    logic                      ov_reg, ov_next;
    logic [DATA_W-1:0]         oval_reg, oval_next;
    logic [IDX_W-1:0]          oidx_reg, oidx_next;

    logic [3:0]                base;
    logic signed [SUM_W-1:0]   col_sum;
    logic [1:0]                col_cnt;
    logic [ROW_W-1:0]          crow;
    logic signed [DATA_W-1:0]  center;
    logic signed [DATA_W-1:0]  here_c;
    logic                      center_valid;
    logic                      scale;
    logic [WEIGHT_W-1:0]       w_abs;
    logic [8:0]                kw;
    logic [K_W-1:0]            k_calc;
    logic [SUM_W-1:0]          acc_mag;
    logic [PROD_W-1:0]         prod_mag;
    logic signed [SUM_W-1:0]   q_avg;
    logic signed [DIV_W-1:0]   q_term;
    logic signed [DIV_W-1:0]   total;
    logic                      fits;
    logic [DATA_W-1:0]         sat_val;
    logic                      out_free;

    always_comb
    begin
        logic [3:0]               idx;
        logic signed [DATA_W-1:0] m;
        logic signed [DATA_W-1:0] g;
        logic signed [DATA_W:0]   diff;
        base    = {1'b0, c_reg, 1'b0} + {2'b00, c_reg};
        col_sum = '0;
        col_cnt = '0;
        for (int r = 0; r < 3; r++)
        begin
            idx  = base + 4'(r);
            m    = head.merge[idx];
            g    = head.regional[idx];
            diff = (DATA_W+1)'(m) - (DATA_W+1)'(g);
            if (m < cfg.null_threshold)
            begin
                col_sum = col_sum + SUM_W'(diff);
                col_cnt = col_cnt + 2'd1;
            end
        end
    end

    assign crow         = (cfg.center_row == 2'd3) ? 2'd2 : cfg.center_row;
    assign center       = head.merge[4'd3 + {2'b00, crow}];
    assign here_c       = head.here;
    assign center_valid = (center < cfg.null_threshold);
    assign scale        = (center <= cfg.null_threshold) || (cnt_reg != COUNT_W'(1));
    assign w_abs        = cfg.count_gain[WEIGHT_W-1] ? WEIGHT_W'(-cfg.count_gain)
                                                     : cfg.count_gain;
    assign kw           = 9'(cnt_reg) * 9'(w_abs);
    assign k_calc       = !scale ? K_W'(cnt_reg)
                        : (kw > 9'(WEIGHT_CAP)) ? K_W'(WEIGHT_CAP) : kw[K_W-1:0];
    assign acc_mag      = acc_reg[SUM_W-1] ? SUM_W'(-acc_reg) : acc_reg;
    assign prod_mag     = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : prod_reg;
    assign q_avg        = acc_reg[SUM_W-1] ? -$signed(div_quotient[SUM_W-1:0])
                                           : $signed(div_quotient[SUM_W-1:0]);
    assign q_term       = prod_reg[PROD_W-1] ? -$signed(div_quotient) : $signed(div_quotient);
    assign total        = DIV_W'(here_c) + q_term;
    assign fits         = (total[DIV_W-1:DATA_W-1] == {(DIV_W-DATA_W+1){total[DATA_W-1]}});
    assign sat_val      = fits ? total[DATA_W-1:0]
                        : (total[DIV_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                          : {1'b0, {(DATA_W-1){1'b1}}});
    assign out_free     = !ov_reg || results.ready;

    always_comb
    begin
        state_next = state_reg;
        c_next     = c_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        avg_next   = avg_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        ov_next    = ov_reg && !results.ready;
        oval_next  = oval_reg;
        oidx_next  = oidx_reg;
        pop        = 1'b0;
        div_req    = '{start: 1'b0, mag: '0, divisor: '0};
        unique case (state_reg)
            B_IDLE:
            begin
                c_next   = '0;
                acc_next = '0;
                cnt_next = '0;
                if (head_valid)
                begin
                    state_next = B_SUM;
                end
            end
            B_SUM:
            begin
                acc_next = acc_reg + col_sum;
                cnt_next = cnt_reg + COUNT_W'(col_cnt);
                c_next   = c_reg + 2'd1;
                if (c_reg == 2'd2)
                begin
                    state_next = B_CHK;
                end
            end
            B_CHK:
            begin
                k_next = k_calc;
                if (cnt_reg == '0)
                begin
                    res_next   = here_c;
                    state_next = B_OUT;
                end
                else if (center_valid && cfg.count_gain[WEIGHT_W-1])
                begin
                    res_next   = center;
                    state_next = B_OUT;
                end
                else if (center_valid)
                begin
                    avg_next   = SUM_W'(center) - SUM_W'(here_c);
                    state_next = B_MUL;
                end
                else
                begin
                    div_req.start   = 1'b1;
                    div_req.mag     = DIV_W'(acc_mag) + DIV_W'(cnt_reg >> 1);
                    div_req.divisor = DIVISOR_W'(cnt_reg);
                    state_next      = B_DIV1;
                end
            end
            B_DIV1:
            begin
                if (!div_busy)
                begin
                    avg_next   = q_avg;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                prod_next  = PROD_W'($signed({1'b0, k_reg})) * PROD_W'(avg_reg);
                state_next = B_GO;
            end
            B_GO:
            begin
                div_req.start   = 1'b1;
                div_req.mag     = DIV_W'(prod_mag) + DIV_W'(SCALE_DIV / 2);
                div_req.divisor = DIVISOR_W'(SCALE_DIV);
                state_next      = B_DIV2;
            end
            B_DIV2:
            begin
                if (!div_busy)
                begin
                    res_next   = sat_val;
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oval_next  = res_reg;
                    oidx_next  = head.column_index;
                    pop        = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg    <= c_next;
        acc_reg  <= acc_next;
        cnt_reg  <= cnt_next;
        k_reg    <= k_next;
        avg_reg  <= avg_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        oval_reg <= oval_next;
        oidx_reg <= oidx_next;
    end

    assign results.valid        = ov_reg;
    assign results.merged_value = oval_reg;
    assign results.column_index = oidx_reg;

    a_job_present: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_IDLE) |-> head_valid)
        else $error("Window evaluation runs without a queued job.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CHK) |-> (cnt_reg <= COUNT_W'(WIN_SIZE)))
        else $error("Valid sample count exceeds the window size.");

    a_weight_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_MUL) |-> (k_reg <= K_W'(WEIGHT_CAP)))
        else $error("Weight exceeds its cap.");

    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> results.valid)
        else $error("Retired job left no result on the output.");

endmodule
